// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, sizes and helpers for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	localparam int PIX_W  = 32;
	localparam int CHAN_W = 8;
	localparam int NCHAN  = 3;
	localparam int LINE_W = NCHAN * CHAN_W;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 16;
	localparam int WID_W  = 11;
	localparam int HGT_W  = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
	localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(768);
	localparam logic [WID_W-1:0] WIDTH_LIMIT  = WID_W'(MAX_WIDTH);

	// Floor of s/9 for s below 32768: (s * 7282) >> 16.
	localparam int SUM_W      = 12;
	localparam int DIV9_SHIFT = 16;
	localparam int DIV9_MUL_W = 13;
	localparam int PROD_W     = SUM_W + DIV9_MUL_W;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(7282);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       first;
		res_t       second;
	} push_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [LINE_W-1:0] older;
		logic [LINE_W-1:0] newer;
	} lb_wr_t;

	function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(DIV9_MUL);
		return p[DIV9_SHIFT +: CHAN_W];
	endfunction

endpackage

// ===== rtl/bb3_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// bb3_pix_in_if
// Input pixel channel: valid/ready handshake with one pixel word.
// ----------------------------------------------------------------------------
interface bb3_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic [bb3_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/bb3_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// bb3_pix_out_if
// Result channel: valid/ready handshake with pixel, coordinates and last.
// ----------------------------------------------------------------------------
interface bb3_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [bb3_pkg::PIX_W-1:0] pixel_out;
	logic [bb3_pkg::COL_W-1:0] out_col;
	logic [bb3_pkg::ROW_W-1:0] out_row;
	logic                      last;

	modport source (output valid, output pixel_out, output out_col, output out_row,
		output last, input ready);
	modport sink (input valid, input pixel_out, input out_col, input out_row,
		input last, output ready);
endinterface

// ===== rtl/bb3_cfg.sv =====
// ----------------------------------------------------------------------------
// bb3_cfg
// APB register block holding the frame width and height.
// ----------------------------------------------------------------------------
module bb3_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bb3_pkg::PADDR_W-1:0] paddr,
	input  logic [bb3_pkg::PDATA_W-1:0] pwdata,
	output logic [bb3_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output bb3_pkg::cfg_t               cfg
);

	bb3_pkg::cfg_t     cfg_q;
	bb3_pkg::reg_idx_t sel;
	logic              wr;

	assign sel    = bb3_pkg::reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= bb3_pkg::WIDTH_RESET;
			cfg_q.height <= bb3_pkg::HEIGHT_RESET;
		end else if (wr) begin
			unique case (sel)
				bb3_pkg::REG_IMAGE_WIDTH:  cfg_q.width  <= pwdata[bb3_pkg::WID_W-1:0];
				bb3_pkg::REG_IMAGE_HEIGHT: cfg_q.height <= pwdata[bb3_pkg::HGT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			bb3_pkg::REG_IMAGE_WIDTH:  prdata = bb3_pkg::PDATA_W'(cfg_q.width);
			bb3_pkg::REG_IMAGE_HEIGHT: prdata = bb3_pkg::PDATA_W'(cfg_q.height);
		endcase
	end

endmodule

// ===== rtl/bb3_line_buf.sv =====
// ----------------------------------------------------------------------------
// bb3_line_buf
// Two row stores (rows r-2 and r-1), one registered read and one write a cycle.
// ----------------------------------------------------------------------------
module bb3_line_buf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [bb3_pkg::ADDR_W-1:0] rd_addr,
	input  bb3_pkg::lb_wr_t            wr,
	output logic [bb3_pkg::LINE_W-1:0] top,
	output logic [bb3_pkg::LINE_W-1:0] mid
);

	logic [bb3_pkg::LINE_W-1:0] older_mem [bb3_pkg::MAX_WIDTH];
	logic [bb3_pkg::LINE_W-1:0] newer_mem [bb3_pkg::MAX_WIDTH];
	logic [bb3_pkg::LINE_W-1:0] older_rd_q;
	logic [bb3_pkg::LINE_W-1:0] newer_rd_q;
	logic [bb3_pkg::LINE_W-1:0] older_fwd_q;
	logic [bb3_pkg::LINE_W-1:0] newer_fwd_q;
	logic                       fwd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			older_mem[wr.addr] <= wr.older;
			newer_mem[wr.addr] <= wr.newer;
		end
		if (rd_en) begin
			older_rd_q <= older_mem[rd_addr];
			newer_rd_q <= newer_mem[rd_addr];
		end
	end

	// A read that meets a write to the same entry takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			older_fwd_q <= wr.older;
			newer_fwd_q <= wr.newer;
		end
	end

	assign top = fwd_q ? older_fwd_q : older_rd_q;
	assign mid = fwd_q ? newer_fwd_q : newer_rd_q;

endmodule

// ===== rtl/bb3_window.sv =====
// ----------------------------------------------------------------------------
// bb3_window
// Two-column 3x3 window and the per-channel mean of nine pixels.
// ----------------------------------------------------------------------------
module bb3_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [bb3_pkg::LINE_W-1:0] top,
	input  logic [bb3_pkg::LINE_W-1:0] mid,
	input  logic [bb3_pkg::LINE_W-1:0] bot,
	output logic [bb3_pkg::LINE_W-1:0] mean
);

	// Columns c-2 (index 0) and c-1 (index 1), rows top, middle, bottom.
	logic [bb3_pkg::LINE_W-1:0] top_q [2];
	logic [bb3_pkg::LINE_W-1:0] mid_q [2];
	logic [bb3_pkg::LINE_W-1:0] bot_q [2];
	logic [bb3_pkg::SUM_W-1:0]  sum   [bb3_pkg::NCHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				top_q[i] <= '0;
				mid_q[i] <= '0;
				bot_q[i] <= '0;
			end
		end else if (advance) begin
			top_q[0] <= top_q[1];
			mid_q[0] <= mid_q[1];
			bot_q[0] <= bot_q[1];
			top_q[1] <= top;
			mid_q[1] <= mid;
			bot_q[1] <= bot;
		end
	end

	always_comb begin
		for (int k = 0; k < bb3_pkg::NCHAN; k++) begin
			sum[k] = bb3_pkg::SUM_W'(top_q[0][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(mid_q[0][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(bot_q[0][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(top_q[1][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(mid_q[1][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(bot_q[1][k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(top[k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(mid[k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W])
				+ bb3_pkg::SUM_W'(bot[k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W]);
			mean[k*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W] = bb3_pkg::div9(sum[k]);
		end
	end

endmodule

// ===== rtl/bb3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Small result queue: takes up to two items a cycle, gives one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module bb3_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  bb3_pkg::push_t push,
	output logic           room,
	bb3_pix_out_if.source  pix_out
);

	bb3_pkg::res_t                   mem [bb3_pkg::FIFO_DEPTH];
	logic [bb3_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [bb3_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [bb3_pkg::FIFO_CNT_W-1:0]  count_q;
	logic                            pop;
	bb3_pkg::res_t                   head;

	assign pop  = pix_out.valid && pix_out.ready;
	assign room = count_q <= bb3_pkg::FIFO_CNT_W'(bb3_pkg::FIFO_DEPTH - 2);
	assign head = mem[rd_ptr_q];

	assign pix_out.valid     = count_q != '0;
	assign pix_out.pixel_out = head.pixel;
	assign pix_out.out_col   = head.col;
	assign pix_out.out_row   = head.row;
	assign pix_out.last      = head.last;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_q + bb3_pkg::FIFO_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bb3_pkg::FIFO_PTR_W'(push.cnt);
			rd_ptr_q <= rd_ptr_q + bb3_pkg::FIFO_PTR_W'(pop);
			count_q  <= count_q + bb3_pkg::FIFO_CNT_W'(push.cnt)
				- bb3_pkg::FIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |->
		(count_q + bb3_pkg::FIFO_CNT_W'(push.cnt) <= bb3_pkg::FIFO_CNT_W'(bb3_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

endmodule

// ===== rtl/box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 mean filter over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock unless stage s1 is held. Its column and row
// are counted against the configured width and height; the line stores (two
// rows of 1024 x 24 bits, one read and one write per cycle) are read on the
// accept edge, and stage s1 forms the window sums and mean and writes the
// results into a 4-entry result queue once it has room. Border pixels pass
// through unchanged; an interior pixel leaves when its lower-right neighbor
// arrives. A pixel gives 0, 1 or 2 results; the queue drains one per cycle
// while the receiver is ready, so on the last row and right column, where
// pixels give two results, input pauses while the queue holds over two
// items. Line stores are not cleared after reset. Configure only while idle.
// ----------------------------------------------------------------------------
module box_blur_3x3 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bb3_pkg::PADDR_W-1:0] paddr,
	input  logic [bb3_pkg::PDATA_W-1:0] pwdata,
	output logic [bb3_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	bb3_pix_in_if.sink                  pix_in,
	bb3_pix_out_if.source               pix_out
);

	bb3_pkg::cfg_t              cfg;
	logic [bb3_pkg::WID_W-1:0]  w_eff;
	logic [bb3_pkg::HGT_W-1:0]  h_eff;
	logic [bb3_pkg::COL_W-1:0]  col_q;
	logic [bb3_pkg::ROW_W-1:0]  row_q;
	logic                       restart;
	logic [bb3_pkg::COL_W-1:0]  c0;
	logic [bb3_pkg::ROW_W-1:0]  r0;
	logic                       interior0;
	logic                       border0;
	logic                       row_end0;
	logic                       in_acc;

	logic                       v_s1;
	logic [bb3_pkg::PIX_W-1:0]  pix_s1;
	logic [bb3_pkg::COL_W-1:0]  c_s1;
	logic [bb3_pkg::ROW_W-1:0]  r_s1;
	logic                       interior_s1;
	logic                       border_s1;
	logic                       s1_fire;

	logic [bb3_pkg::LINE_W-1:0] top;
	logic [bb3_pkg::LINE_W-1:0] mid;
	logic [bb3_pkg::LINE_W-1:0] mean;
	bb3_pkg::lb_wr_t            lb_wr;
	bb3_pkg::push_t             push;
	bb3_pkg::res_t              res_int;
	bb3_pkg::res_t              res_brd;
	logic                       room;

	bb3_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Effective frame size: zero reads as one, width saturates at the store depth.
	always_comb begin
		priority if (cfg.width == '0) begin
			w_eff = bb3_pkg::WID_W'(1);
		end else if (cfg.width > bb3_pkg::WIDTH_LIMIT) begin
			w_eff = bb3_pkg::WIDTH_LIMIT;
		end else begin
			w_eff = cfg.width;
		end
		h_eff = (cfg.height == '0) ? bb3_pkg::HGT_W'(1) : cfg.height;
	end

	assign restart = (bb3_pkg::WID_W'(col_q) >= w_eff) || (row_q >= h_eff);
	assign c0 = restart ? '0 : col_q;
	assign r0 = restart ? '0 : row_q;
	assign interior0 = (c0 >= bb3_pkg::COL_W'(2)) && (r0 >= bb3_pkg::ROW_W'(2));
	assign row_end0  = (bb3_pkg::WID_W'(c0) == w_eff - bb3_pkg::WID_W'(1));
	assign border0   = (r0 == '0) || (r0 == h_eff - bb3_pkg::HGT_W'(1))
		|| (c0 == '0) || row_end0;

	assign s1_fire      = v_s1 && room;
	assign pix_in.ready = !v_s1 || room;
	assign in_acc       = pix_in.valid && pix_in.ready;

	// Position counters for the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end0) begin
				col_q <= '0;
				row_q <= (r0 == h_eff - bb3_pkg::HGT_W'(1)) ? '0 : r0 + bb3_pkg::ROW_W'(1);
			end else begin
				col_q <= c0 + bb3_pkg::COL_W'(1);
				row_q <= r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= pix_in.pixel_in;
			c_s1        <= c0;
			r_s1        <= r0;
			interior_s1 <= interior0;
			border_s1   <= border0;
		end
	end

	assign lb_wr.en    = s1_fire;
	assign lb_wr.addr  = c_s1[bb3_pkg::ADDR_W-1:0];
	assign lb_wr.older = mid;
	assign lb_wr.newer = pix_s1[bb3_pkg::LINE_W-1:0];

	bb3_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (c0[bb3_pkg::ADDR_W-1:0]),
		.wr      (lb_wr),
		.top     (top),
		.mid     (mid)
	);

	bb3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_fire),
		.top     (top),
		.mid     (mid),
		.bot     (pix_s1[bb3_pkg::LINE_W-1:0]),
		.mean    (mean)
	);

	always_comb begin
		res_int.pixel = {{(bb3_pkg::PIX_W - bb3_pkg::LINE_W){1'b0}}, mean};
		res_int.col   = c_s1 - bb3_pkg::COL_W'(1);
		res_int.row   = r_s1 - bb3_pkg::ROW_W'(1);
		res_int.last  = !border_s1;
		res_brd.pixel = pix_s1;
		res_brd.col   = c_s1;
		res_brd.row   = r_s1;
		res_brd.last  = 1'b1;

		push.second = res_brd;
		if (interior_s1) begin
			push.first = res_int;
		end else begin
			push.first = res_brd;
		end
		if (s1_fire) begin
			push.cnt = 2'(interior_s1) + 2'(border_s1);
		end else begin
			push.cnt = 2'd0;
		end
	end

	bb3_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.pix_out (pix_out)
	);

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && v_s1) |-> s1_fire)
		else $error("item accepted over a held stage");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && interior_s1) |-> (c_s1 >= bb3_pkg::COL_W'(2)) && (r_s1 >= bb3_pkg::ROW_W'(2)))
		else $error("interior result without a full window");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !in_acc) |=> !v_s1)
		else $error("stage still valid after its item left");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (bb3_pkg::WID_W'(col_q) < w_eff))
		else $error("column counter beyond frame width");

endmodule

// ===== test/box_blur_3x3_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_tb
// Feeds whole raster frames of pixels through the 3x3 mean filter at a range
// of frame sizes. Each accepted pixel is run through a local model of the
// window and the line stores, and every result item is checked in order
// against it. Sender and receiver idle at random. One long receiver stall
// backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module box_blur_3x3_tb;

	localparam int RANDOM_ITEMS  = 1250;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_WIDTH    = 64;
	localparam int HOLD_ROWS     = 3;
	localparam int NEIGHBORS     = 9;
	localparam int WIN_DEPTH     = 6;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bb3_pkg::PADDR_W-1:0] paddr;
	logic [bb3_pkg::PDATA_W-1:0] pwdata;
	logic [bb3_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	bb3_pix_in_if  pix_in_bus ();
	bb3_pix_out_if pix_out_bus ();

	box_blur_3x3 u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	logic [bb3_pkg::PIX_W-1:0] pixel_backlog [$];
	bb3_pkg::res_t             due_out [$];
	int                        mismatch_count = 0;
	int                        tx_idle_pct;
	int                        rx_idle_pct;
	bit                        hold_req;
	bit                        hold_off;
	bit                        in_taken;

	// filter state mirror
	logic [bb3_pkg::WID_W-1:0]  cur_width;
	logic [bb3_pkg::HGT_W-1:0]  cur_height;
	logic [bb3_pkg::LINE_W-1:0] row_m2 [bb3_pkg::MAX_WIDTH];
	logic [bb3_pkg::LINE_W-1:0] row_m1 [bb3_pkg::MAX_WIDTH];
	logic [bb3_pkg::LINE_W-1:0] win_col [WIN_DEPTH];
	int unsigned                pos_col;
	int unsigned                pos_row;

	always #5 clk = ~clk;

	function automatic int unsigned eff_width(input logic [bb3_pkg::WID_W-1:0] w);
		if (w == 0)
			return 1;
		return (w > bb3_pkg::MAX_WIDTH) ? bb3_pkg::MAX_WIDTH : w;
	endfunction

	function automatic int unsigned eff_height(input logic [bb3_pkg::HGT_W-1:0] h);
		return (h == 0) ? 1 : h;
	endfunction

	task automatic blur_pixel(input logic [bb3_pkg::PIX_W-1:0] pix);
		int unsigned                w, h, c, r, s;
		int                         ch, k;
		logic [bb3_pkg::LINE_W-1:0] top, mid, bot, avg;
		bit                         on_border;
		w = eff_width(cur_width);
		h = eff_height(cur_height);
		// restart the frame when the counters lie outside the current size
		if (pos_col >= w || pos_row >= h) begin
			pos_col = 0;
			pos_row = 0;
		end
		c = pos_col;
		r = pos_row;
		top = row_m2[c];
		mid = row_m1[c];
		bot = pix[bb3_pkg::LINE_W-1:0];
		on_border = (r == 0 || r == h - 1 || c == 0 || c == w - 1);
		if (c >= 2 && r >= 2) begin
			for (ch = 0; ch < bb3_pkg::NCHAN; ch++) begin
				s = top[ch*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W]
					+ mid[ch*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W]
					+ bot[ch*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W];
				for (k = 0; k < WIN_DEPTH; k++)
					s += win_col[k][ch*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W];
				avg[ch*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W] = bb3_pkg::CHAN_W'(s / NEIGHBORS);
			end
			due_out.push_back('{pixel: bb3_pkg::PIX_W'(avg), col: bb3_pkg::COL_W'(c - 1),
				row: bb3_pkg::ROW_W'(r - 1), last: !on_border});
		end
		if (on_border)
			due_out.push_back('{pixel: pix, col: bb3_pkg::COL_W'(c),
				row: bb3_pkg::ROW_W'(r), last: 1'b1});
		for (k = 0; k < 3; k++)
			win_col[k] = win_col[k + 3];
		win_col[3] = top;
		win_col[4] = mid;
		win_col[5] = bot;
		row_m2[c] = mid;
		row_m1[c] = bot;
		if (c + 1 >= w) begin
			pos_col = 0;
			pos_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			pos_col = c + 1;
		end
	endtask

	function automatic void push_frame(input int unsigned count);
		logic [bb3_pkg::PIX_W-1:0] pix;
		repeat (count) begin
			pix = $urandom;
			// saturate or clear the channels now and then to reach the sum extremes
			case ($urandom_range(7))
				0: pix[bb3_pkg::LINE_W-1:0] = '1;
				1: pix[bb3_pkg::LINE_W-1:0] = '0;
				default: ;
			endcase
			pixel_backlog.push_back(pix);
		end
	endfunction

	task automatic write_reg(input bb3_pkg::reg_idx_t idx,
		input logic [bb3_pkg::PDATA_W-1:0] value);
		logic [bb3_pkg::PDATA_W-1:0] stored;
		stored = (idx == bb3_pkg::REG_IMAGE_WIDTH)
			? bb3_pkg::PDATA_W'(value[bb3_pkg::WID_W-1:0])
			: bb3_pkg::PDATA_W'(value[bb3_pkg::HGT_W-1:0]);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bb3_pkg::PADDR_W'(4 * idx);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bb3_pkg::REG_IMAGE_WIDTH)
			cur_width = value[bb3_pkg::WID_W-1:0];
		else
			cur_height = value[bb3_pkg::HGT_W-1:0];
		// read back through a second transfer
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			mismatch_count++;
			$display("%0t: register %s read back: expected %h, actual %h",
				$time, idx.name(), stored, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pix_in_bus.valid || due_out.size() != 0)
			@(posedge clk);
		// let a pixel that gives no result clear the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender and receiver
	always @(negedge clk) begin
		if (!pix_in_bus.valid || in_taken) begin
			if (pixel_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				pix_in_bus.valid    <= 1'b1;
				pix_in_bus.pixel_in <= pixel_backlog.pop_front();
			end else begin
				pix_in_bus.valid <= 1'b0;
			end
		end
		pix_out_bus.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		bb3_pkg::res_t got;
		bb3_pkg::res_t want;
		in_taken = arst_n && pix_in_bus.valid && pix_in_bus.ready;
		if (in_taken)
			blur_pixel(pix_in_bus.pixel_in);
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			got = '{pixel: pix_out_bus.pixel_out, col: pix_out_bus.out_col,
				row: pix_out_bus.out_row, last: pix_out_bus.last};
			if (due_out.size() == 0) begin
				mismatch_count++;
				$display("%0t: expected no item, actual pixel=%h col=%0d row=%0d last=%b",
					$time, got.pixel, got.col, got.row, got.last);
			end else begin
				want = due_out.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: expected %h/%0d/%0d/%b, actual %h/%0d/%0d/%b", $time,
						want.pixel, want.col, want.row, want.last,
						got.pixel, got.col, got.row, got.last);
				end
			end
		end
	end

	// long receiver stall, counted here once requested
	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[box_blur_3x3] ERROR");
		$finish;
	end

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned sent;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		pix_in_bus.valid    = 1'b0;
		pix_in_bus.pixel_in = '0;
		pix_out_bus.ready   = 1'b0;
		tx_idle_pct = 24;
		rx_idle_pct = 67;
		hold_req    = 1'b0;
		cur_width   = bb3_pkg::WIDTH_RESET;
		cur_height  = bb3_pkg::HEIGHT_RESET;
		pos_col     = 0;
		pos_row     = 0;
		foreach (row_m2[i]) row_m2[i] = '0;
		foreach (row_m1[i]) row_m1[i] = '0;
		foreach (win_col[i]) win_col[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// a few pixels at the reset size, then shrink below the column count
		pixel_backlog.push_back(32'h0000_0000);
		pixel_backlog.push_back(32'hFFFF_FFFF);
		pixel_backlog.push_back(32'h8080_8080);
		wait_idle();
		write_reg(bb3_pkg::REG_IMAGE_WIDTH, 3);
		write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 3);
		// smallest frame with an interior pixel, all channels at full scale
		repeat (9) pixel_backlog.push_back(32'hFFFF_FFFF);
		wait_idle();
		// zero sizes act as one
		write_reg(bb3_pkg::REG_IMAGE_WIDTH, 0);
		write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 0);
		pixel_backlog.push_back(32'hA5A5_A5A5);
		pixel_backlog.push_back(32'h5A5A_5A5A);
		wait_idle();
		// tallest frame: two rows only, then shrink below the row count
		write_reg(bb3_pkg::REG_IMAGE_WIDTH, 3);
		write_reg(bb3_pkg::REG_IMAGE_HEIGHT, '1);
		push_frame(6);
		wait_idle();
		write_reg(bb3_pkg::REG_IMAGE_WIDTH, 2);
		write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 2);
		push_frame(4);
		wait_idle();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 24;
				rx_idle_pct = 67;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 67;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				if (!hold_req) begin
					// wider frame under a long receiver stall, input backs up
					write_reg(bb3_pkg::REG_IMAGE_WIDTH, HOLD_WIDTH);
					write_reg(bb3_pkg::REG_IMAGE_HEIGHT, HOLD_ROWS);
					push_frame(HOLD_WIDTH * HOLD_ROWS);
					sent += HOLD_WIDTH * HOLD_ROWS;
					hold_req = 1'b1;
					wait_idle();
				end
			end
			case ($urandom_range(9))
				0: w = 0;
				1: w = $urandom_range(1, 2);
				2: w = $urandom_range(13, 32);
				default: w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(9))
				0: h = 0;
				1: h = $urandom_range(1, 2);
				2: h = $urandom_range(9, 16);
				default: h = $urandom_range(3, 8);
			endcase
			write_reg(bb3_pkg::REG_IMAGE_WIDTH, w);
			write_reg(bb3_pkg::REG_IMAGE_HEIGHT, h);
			n = eff_width(bb3_pkg::WID_W'(w)) * eff_height(bb3_pkg::HGT_W'(h))
				* $urandom_range(1, 2);
			push_frame(n);
			sent += n;
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("[box_blur_3x3] OK");
		else
			$display("[box_blur_3x3] ERROR");
		$finish;
	end

endmodule
